### rtl/closest_video_mode_select_unit_macros.svh
// Assertion macros used by the closest video mode selector.
`ifndef CLOSEST_VIDEO_MODE_SELECT_UNIT_MACROS_SVH
`define CLOSEST_VIDEO_MODE_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CVMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CVMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cvms_pkg.sv
// Types and constants shared by the closest video mode selector.
`timescale 1ns / 1ps
package cvms_pkg;

	typedef enum logic [2:0] {
		REG_WANT_RED     = 3'd0,
		REG_WANT_GREEN   = 3'd1,
		REG_WANT_BLUE    = 3'd2,
		REG_WANT_WIDTH   = 3'd3,
		REG_WANT_HEIGHT  = 3'd4,
		REG_WANT_REFRESH = 3'd5
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int COLOR_W = 8;
	localparam int SIZE_W  = 29;
	localparam int RATE_W  = 32;

	// Largest possible color cost: three channels of at most 63 each.
	localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd189;

	localparam logic [5:0]  DONT_CARE_BITS  = 6'h3F;
	localparam logic [10:0] PREFER_HIGHEST  = 11'h7FF;

	typedef struct packed {
		logic [4:0]  red;
		logic [4:0]  green;
		logic [4:0]  blue;
		logic [13:0] width;
		logic [13:0] height;
		logic [9:0]  refresh;
	} mode_t;

	typedef struct packed {
		logic [5:0]  red;
		logic [5:0]  green;
		logic [5:0]  blue;
		logic [13:0] width;
		logic [13:0] height;
		logic [10:0] refresh;
	} want_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [SIZE_W-1:0]  size;
		logic [RATE_W-1:0]  rate;
	} cost_t;

	typedef struct packed {
		mode_t mode;
		cost_t cost;
		logic  last;
	} cand_t;

	typedef struct packed {
		logic [7:0] index;
		mode_t      mode;
	} result_t;

	localparam want_t WANT_RESET = '{
		red:     DONT_CARE_BITS,
		green:   DONT_CARE_BITS,
		blue:    DONT_CARE_BITS,
		width:   14'd0,
		height:  14'd0,
		refresh: PREFER_HIGHEST
	};

endpackage

### rtl/cvms_cfg.sv
// Configuration register file holding the desired video mode.
`timescale 1ns / 1ps
module cvms_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cvms_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cvms_pkg::CFG_DATA_W-1:0]   cfg_data,
	output cvms_pkg::want_t                   want
);

	cvms_pkg::want_t want_q;

	assign cfg_ready = 1'b1;
	assign want      = want_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q <= cvms_pkg::WANT_RESET;
		end else if (cfg_valid) begin
			unique case (cvms_pkg::cfg_reg_t'(cfg_index))
				cvms_pkg::REG_WANT_RED:     want_q.red     <= cfg_data[5:0];
				cvms_pkg::REG_WANT_GREEN:   want_q.green   <= cfg_data[5:0];
				cvms_pkg::REG_WANT_BLUE:    want_q.blue    <= cfg_data[5:0];
				cvms_pkg::REG_WANT_WIDTH:   want_q.width   <= cfg_data[13:0];
				cvms_pkg::REG_WANT_HEIGHT:  want_q.height  <= cfg_data[13:0];
				cvms_pkg::REG_WANT_REFRESH: want_q.refresh <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/cvms_cost.sv
// Input register and cost logic that scores each candidate mode.
`timescale 1ns / 1ps
module cvms_cost (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cvms_pkg::mode_t in_mode,
	input  logic            in_last,
	input  cvms_pkg::want_t want,
	output logic            cand_valid,
	input  logic            cand_ready,
	output cvms_pkg::cand_t cand
);

	function automatic logic [5:0] chan_cost(input logic [5:0] want_bits, input logic [4:0] have);
		logic signed [6:0] d;
		logic [5:0]        r;
		d = $signed({2'b00, have}) - $signed({want_bits[5], want_bits});
		r = d[6] ? 6'(-d) : d[5:0];
		if (want_bits == cvms_pkg::DONT_CARE_BITS) begin
			r = 6'd0;
		end
		return r;
	endfunction

	logic            v_s1;
	cvms_pkg::mode_t mode_s1;
	logic            last_s1;

	logic [cvms_pkg::COLOR_W-1:0] color_c;
	logic [cvms_pkg::RATE_W-1:0]  rate_c;
	logic signed [11:0]           rdiff;
	logic signed [14:0]           wdiff;
	logic signed [14:0]           hdiff;
	logic [13:0]                  dw_c;
	logic [13:0]                  dh_c;
	logic [27:0]                  sq_w;
	logic [27:0]                  sq_h;
	logic [cvms_pkg::SIZE_W-1:0]  size_c;

	assign in_ready = !v_s1 || cand_ready;

	always_comb begin
		color_c = 8'(chan_cost(want.red, mode_s1.red))
		        + 8'(chan_cost(want.green, mode_s1.green))
		        + 8'(chan_cost(want.blue, mode_s1.blue));

		rdiff = $signed({2'b00, mode_s1.refresh}) - $signed({want.refresh[10], want.refresh});
		if (want.refresh == cvms_pkg::PREFER_HIGHEST) begin
			rate_c = ~{22'd0, mode_s1.refresh};
		end else begin
			rate_c = {21'd0, (rdiff[11] ? 11'(-rdiff) : rdiff[10:0])};
		end

		wdiff = $signed({1'b0, mode_s1.width}) - $signed({1'b0, want.width});
		hdiff = $signed({1'b0, mode_s1.height}) - $signed({1'b0, want.height});
		dw_c  = wdiff[14] ? 14'(-wdiff) : wdiff[13:0];
		dh_c  = hdiff[14] ? 14'(-hdiff) : hdiff[13:0];

		sq_w   = dw_c * dw_c;
		sq_h   = dh_c * dh_c;
		size_c = 29'(sq_w) + 29'(sq_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= in_mode;
			last_s1 <= in_last;
		end
	end

	assign cand_valid      = v_s1;
	assign cand.mode       = mode_s1;
	assign cand.last       = last_s1;
	assign cand.cost.color = color_c;
	assign cand.cost.size  = size_c;
	assign cand.cost.rate  = rate_c;

endmodule

### rtl/cvms_best.sv
// Running best-mode tracker, mode counter and result register.
`timescale 1ns / 1ps
`include "closest_video_mode_select_unit_macros.svh"
module cvms_best #(
	parameter int MAX_MODES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cand_valid,
	output logic              cand_ready,
	input  cvms_pkg::cand_t   cand,
	output logic              out_valid,
	input  logic              out_ready,
	output cvms_pkg::result_t out_word
);

	localparam int CNT_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_MODES - 1);

	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             best_pos_q;
	logic [cvms_pkg::COLOR_W-1:0] least_color_q;
	logic [cvms_pkg::SIZE_W-1:0]  least_size_q;
	logic [cvms_pkg::RATE_W-1:0]  least_rate_q;
	cvms_pkg::mode_t              best_mode_q;
	logic                         out_valid_q;
	cvms_pkg::result_t            out_q;

	logic             upd;
	logic             better;
	cvms_pkg::mode_t  sel_mode;
	logic [CNT_W-1:0] sel_pos;

	// A last word may only retire once the result register is free.
	assign cand_ready = !(cand.last && out_valid_q && !out_ready);
	assign upd        = cand_valid && cand_ready;

	always_comb begin
		better = (cand.cost.color < least_color_q) ||
		         (cand.cost.color == least_color_q && cand.cost.size < least_size_q) ||
		         (cand.cost.color == least_color_q && cand.cost.size == least_size_q &&
		          cand.cost.rate < least_rate_q);
		sel_mode = better ? cand.mode : best_mode_q;
		sel_pos  = better ? cnt_q : best_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			best_pos_q    <= '0;
			least_color_q <= '1;
			least_size_q  <= '1;
			least_rate_q  <= '1;
			best_mode_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (upd && cand.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (upd) begin
				if (cand.last) begin
					cnt_q         <= '0;
					best_pos_q    <= '0;
					least_color_q <= '1;
					least_size_q  <= '1;
					least_rate_q  <= '1;
					best_mode_q   <= '0;
				end else begin
					cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
					if (better) begin
						best_pos_q    <= cnt_q;
						least_color_q <= cand.cost.color;
						least_size_q  <= cand.cost.size;
						least_rate_q  <= cand.cost.rate;
						best_mode_q   <= cand.mode;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd && cand.last) begin
			out_q.index <= 8'(sel_pos);
			out_q.mode  <= sel_mode;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`CVMS_ASSERT_NOW(a_no_overrun, upd && cand.last, !out_valid_q || out_ready, "result overwritten while stalled")
	`CVMS_ASSERT_NEXT(a_result_follows_last, upd && cand.last, out_valid_q, "no result after last word")
	`CVMS_ASSERT_NEXT(a_search_restarts, upd && cand.last, cnt_q == '0 && least_color_q == '1, "search not cleared after last word")
	`CVMS_ASSERT_NOW(a_color_range, 1'b1, least_color_q <= cvms_pkg::COLOR_MAX || least_color_q == '1, "color cost out of range")

endmodule

### rtl/closest_video_mode_select_unit.sv
// Top level of the closest video mode selector.
`timescale 1ns / 1ps
// The block scans a list of display modes, one word per mode on the input
// channel, and keeps the mode that best matches the desired mode held in the
// configuration registers. Cost is compared as color depth difference first,
// then squared size distance, then refresh difference, or highest refresh
// when the wanted refresh is all ones; the earliest mode wins ties. The word
// flagged by mode_last closes the list, and one result word with the position
// and fields of the best mode appears on the output channel. The configuration
// channel is always ready and takes a register index and data; it should only
// be written while no list is in flight. A mode word is scored and compared
// from an input register; retiring the last word loads the result register.
// One word is accepted every cycle; a stalled receiver holds up the input only
// when a further last word reaches the compare stage while a result still
// waits. Reset clears the running best, the mode counter and the result valid
// flag, and loads the configuration with its default values.
module closest_video_mode_select_unit #(
	parameter int MAX_MODES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  mode_red,
	input  logic [4:0]  mode_green,
	input  logic [4:0]  mode_blue,
	input  logic [13:0] mode_width,
	input  logic [13:0] mode_height,
	input  logic [9:0]  mode_refresh,
	input  logic        mode_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  best_index,
	output logic [4:0]  best_red,
	output logic [4:0]  best_green,
	output logic [4:0]  best_blue,
	output logic [13:0] best_width,
	output logic [13:0] best_height,
	output logic [9:0]  best_refresh
);

	cvms_pkg::want_t   want;
	cvms_pkg::mode_t   in_mode;
	cvms_pkg::cand_t   cand;
	cvms_pkg::result_t out_word;
	logic              cand_valid;
	logic              cand_ready;

	assign in_mode.red     = mode_red;
	assign in_mode.green   = mode_green;
	assign in_mode.blue    = mode_blue;
	assign in_mode.width   = mode_width;
	assign in_mode.height  = mode_height;
	assign in_mode.refresh = mode_refresh;

	cvms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.want      (want)
	);

	cvms_cost u_cost (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_mode    (in_mode),
		.in_last    (mode_last),
		.want       (want),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.cand       (cand)
	);

	cvms_best #(
		.MAX_MODES (MAX_MODES)
	) u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.cand       (cand),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

	assign best_index   = out_word.index;
	assign best_red     = out_word.mode.red;
	assign best_green   = out_word.mode.green;
	assign best_blue    = out_word.mode.blue;
	assign best_width   = out_word.mode.width;
	assign best_height  = out_word.mode.height;
	assign best_refresh = out_word.mode.refresh;

endmodule
